// ----- rtl/core/ptcl_pkg.sv -----
// ----------------------------------------------------------------------------
// ptcl_pkg
// Shared types, widths and helpers of the per-request token credit ledger.
// ----------------------------------------------------------------------------
package ptcl_pkg;

  localparam int REQUEST_SLOTS = 1024;
  localparam int COUNT_BITS    = 24;
  localparam int SLOT_BITS     = $clog2(REQUEST_SLOTS);

  localparam int OP_BITS    = 3;
  localparam int IN_SLOT_BITS = 10;
  localparam int AMT_BITS   = 20;
  localparam int TOK_BITS   = 19;
  localparam int BAL_BITS   = 32;
  localparam int AVAIL_BITS = 31;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam int ADD_BITS = ((COUNT_BITS > TOK_BITS) ? COUNT_BITS : TOK_BITS) + 1;
  localparam int RCL_BITS = ((COUNT_BITS > TOK_BITS) ? COUNT_BITS : TOK_BITS) + 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENFORCE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MINT     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_BAL = 2'd2;

  typedef enum logic [OP_BITS-1:0] {
    OP_MINT    = 3'd0,
    OP_CONSUME = 3'd1,
    OP_RECORD  = 3'd2,
    OP_RECLAIM = 3'd3,
    OP_ERASE   = 3'd4,
    OP_SET     = 3'd5
  } op_t;

  typedef struct packed {
    logic                  valid;
    logic [COUNT_BITS-1:0] count;
  } slot_entry_t;

  typedef struct packed {
    logic                enforce;
    logic [TOK_BITS-1:0] mint;
  } cfg_t;

  typedef struct packed {
    logic                load;
    logic [BAL_BITS-1:0] value;
  } bal_load_t;

  typedef struct packed {
    logic                  valid;
    logic                  minted;
    logic [TOK_BITS-1:0]   granted;
    logic [BAL_BITS-1:0]   bal_now;
    logic [AVAIL_BITS-1:0] bal_free;
    logic                  present;
    logic [COUNT_BITS-1:0] count;
  } result_t;

  function automatic logic [COUNT_BITS-1:0] sat_count_add(
    input logic [COUNT_BITS-1:0] c,
    input logic [TOK_BITS-1:0]   n
  );
    logic [ADD_BITS-1:0] s;
    logic [ADD_BITS-1:0] cap;
    cap = ADD_BITS'({COUNT_BITS{1'b1}});
    s   = ADD_BITS'(c) + ADD_BITS'(n);
    if (s > cap) begin
      return {COUNT_BITS{1'b1}};
    end
    return COUNT_BITS'(s);
  endfunction

endpackage

// ----- rtl/core/ptcl_slot_table.sv -----
// ----------------------------------------------------------------------------
// ptcl_slot_table
// Slot memory with registered read, one write port and a clearing sweep.
// ----------------------------------------------------------------------------
module ptcl_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ptcl_pkg::SLOT_BITS-1:0] rd_addr,
  output ptcl_pkg::slot_entry_t         rd_data,
  input  logic                          wr_en,
  input  logic [ptcl_pkg::SLOT_BITS-1:0] wr_addr,
  input  ptcl_pkg::slot_entry_t         wr_data,
  output logic                          clearing
);

  ptcl_pkg::slot_entry_t mem [ptcl_pkg::REQUEST_SLOTS];
  ptcl_pkg::slot_entry_t rd_data_r;

  logic                           clr_r;
  logic                           clr_nxt;
  logic [ptcl_pkg::SLOT_BITS-1:0] clr_idx_r;
  logic [ptcl_pkg::SLOT_BITS-1:0] clr_idx_nxt;

  always_comb begin
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == ptcl_pkg::SLOT_BITS'(ptcl_pkg::REQUEST_SLOTS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

// ----- rtl/core/ptcl_exec.sv -----
// ----------------------------------------------------------------------------
// ptcl_exec
// Request register, slot update, balance register and result register.
// ----------------------------------------------------------------------------
module ptcl_exec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [ptcl_pkg::OP_BITS-1:0]      op,
  input  logic [ptcl_pkg::SLOT_BITS-1:0]    slot,
  input  logic [ptcl_pkg::AMT_BITS-1:0]     amount,
  input  ptcl_pkg::cfg_t                    cfg,
  input  ptcl_pkg::bal_load_t               bal_load,
  input  ptcl_pkg::slot_entry_t             rd_data,
  output logic                              wr_en,
  output logic [ptcl_pkg::SLOT_BITS-1:0]    wr_addr,
  output ptcl_pkg::slot_entry_t             wr_data,
  output ptcl_pkg::result_t                 result
);

  localparam int BB = ptcl_pkg::BAL_BITS;
  localparam int TB = ptcl_pkg::TOK_BITS;
  localparam int CB = ptcl_pkg::COUNT_BITS;
  localparam int RB = ptcl_pkg::RCL_BITS;

  logic                           s0_valid_r;
  logic [ptcl_pkg::OP_BITS-1:0]   s0_op_r;
  logic [ptcl_pkg::SLOT_BITS-1:0] s0_slot_r;
  logic [ptcl_pkg::AMT_BITS-1:0]  s0_amt_r;

  logic                           fwd_valid_r;
  logic [ptcl_pkg::SLOT_BITS-1:0] fwd_slot_r;
  ptcl_pkg::slot_entry_t          fwd_entry_r;

  logic [BB-1:0]      bal_r;
  logic [BB-1:0]      bal_nxt;
  ptcl_pkg::result_t  res_r;
  ptcl_pkg::result_t  res_nxt;
  ptcl_pkg::slot_entry_t cur;
  ptcl_pkg::slot_entry_t ent_nxt;

  always_comb begin
    logic [TB-1:0]         pos;
    logic [CB-1:0]         base;
    logic [BB-2:0]         bpos;
    logic [TB-1:0]         allow;
    logic signed [BB:0]    sum;
    logic signed [RB-1:0]  rcl;
    logic                  rcl_pos;
    logic                  minted;
    logic [TB-1:0]         granted;

    cur = (fwd_valid_r && fwd_slot_r == s0_slot_r) ? fwd_entry_r : rd_data;
    pos = s0_amt_r[ptcl_pkg::AMT_BITS-1] ? '0 : s0_amt_r[TB-1:0];
    base = cur.valid ? cur.count : '0;
    bpos = bal_r[BB-1] ? '0 : bal_r[BB-2:0];
    allow = pos;
    if (cfg.enforce && ((BB-1)'(pos) > bpos)) begin
      allow = bpos[TB-1:0];
    end
    rcl = $signed(RB'(cfg.mint)) - $signed(RB'(cur.count));
    rcl_pos = !rcl[RB-1] && (rcl != '0);
    sum = '0;
    minted  = 1'b0;
    granted = '0;
    ent_nxt = cur;
    bal_nxt = bal_r;

    case (ptcl_pkg::op_t'(s0_op_r))
      ptcl_pkg::OP_MINT: begin
        if (!cur.valid) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.count = '0;
          if (pos != '0) begin
            sum = $signed({bal_r[BB-1], bal_r}) + $signed((BB+1)'(pos));
            minted = 1'b1;
            if (sum[BB] != sum[BB-1]) begin
              bal_nxt = {1'b0, {(BB-1){1'b1}}};
            end else begin
              bal_nxt = sum[BB-1:0];
            end
          end
        end
      end
      ptcl_pkg::OP_CONSUME: begin
        if (allow != '0) begin
          if (cfg.enforce) begin
            bal_nxt = bal_r - BB'(allow);
          end
          ent_nxt.valid = 1'b1;
          ent_nxt.count = ptcl_pkg::sat_count_add(base, allow);
          granted = allow;
        end
      end
      ptcl_pkg::OP_RECORD: begin
        if (pos != '0) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.count = ptcl_pkg::sat_count_add(base, pos);
        end
      end
      ptcl_pkg::OP_RECLAIM: begin
        if (cur.valid) begin
          if (rcl_pos) begin
            sum = $signed({bal_r[BB-1], bal_r}) - $signed((BB+1)'(rcl[TB-1:0]));
            granted = rcl[TB-1:0];
            if (sum[BB] != sum[BB-1]) begin
              bal_nxt = {1'b1, {(BB-1){1'b0}}};
            end else begin
              bal_nxt = sum[BB-1:0];
            end
          end
          ent_nxt.valid = 1'b0;
          ent_nxt.count = '0;
        end
      end
      ptcl_pkg::OP_ERASE: begin
        ent_nxt.valid = 1'b0;
        ent_nxt.count = '0;
      end
      ptcl_pkg::OP_SET: begin
        bal_nxt = BB'($signed(s0_amt_r));
      end
      default: begin
      end
    endcase

    res_nxt.valid    = s0_valid_r;
    res_nxt.minted   = minted;
    res_nxt.granted  = granted;
    res_nxt.bal_now  = bal_nxt;
    res_nxt.bal_free = bal_nxt[BB-1] ? '0 : bal_nxt[BB-2:0];
    res_nxt.present  = ent_nxt.valid;
    res_nxt.count    = ent_nxt.valid ? ent_nxt.count : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      res_r.valid <= 1'b0;
      bal_r       <= '0;
    end else begin
      s0_valid_r  <= accept;
      res_r       <= res_nxt;
      if (s0_valid_r) begin
        fwd_valid_r <= 1'b1;
        bal_r       <= bal_nxt;
      end else if (bal_load.load) begin
        bal_r <= bal_load.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_op_r   <= op;
      s0_slot_r <= slot;
      s0_amt_r  <= amount;
    end
    if (s0_valid_r) begin
      fwd_slot_r  <= s0_slot_r;
      fwd_entry_r <= ent_nxt;
    end
  end

  assign wr_en   = s0_valid_r;
  assign wr_addr = s0_slot_r;
  assign wr_data = ent_nxt;
  assign result  = res_r;

endmodule

// ----- rtl/core/per_request_token_credit_ledger_top.sv -----
// ----------------------------------------------------------------------------
// per_request_token_credit_ledger_top
// Shared credit balance with a per-request slot table.
//
// Requests enter on start with in_operation, in_request_slot and in_amount;
// a request is taken at a clock edge where start is high and busy is low.
// One request can be taken every cycle. Each request yields one result,
// shown with out_valid for one cycle; the request passes through the
// request register and then the result register before it is shown.
// The slot memory is read at the edge that takes a request and written at
// the next edge; a request to the slot just written takes the new entry from
// a bypass register, so back-to-back requests to one slot need no gap.
// After reset the slot memory is swept clear, one slot a cycle, through
// all 1024 slots; busy stays high during the sweep and low afterward.
// The balance resets to zero. Configuration writes on cfg_we take effect at
// once; writing the seed balance register also loads the balance. Write only
// while no request is in flight. The receiver cannot stall: each result is
// shown once.
// ----------------------------------------------------------------------------
module per_request_token_credit_ledger_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [ptcl_pkg::OP_BITS-1:0]            in_operation,
  input  logic [ptcl_pkg::IN_SLOT_BITS-1:0]       in_request_slot,
  input  logic signed [ptcl_pkg::AMT_BITS-1:0]    in_amount,
  output logic                                    out_valid,
  output logic                                    out_minted,
  output logic [ptcl_pkg::TOK_BITS-1:0]           out_granted,
  output logic signed [ptcl_pkg::BAL_BITS-1:0]    out_bal_now,
  output logic [ptcl_pkg::AVAIL_BITS-1:0]         out_bal_free,
  output logic                                    out_entry_present,
  output logic [ptcl_pkg::COUNT_BITS-1:0]         out_entry_count,
  input  logic                                    cfg_we,
  input  logic [ptcl_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [ptcl_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  logic                           enforce_r;
  logic [ptcl_pkg::TOK_BITS-1:0]  mint_r;
  logic                           accept;
  logic                           clearing;
  logic [ptcl_pkg::SLOT_BITS-1:0] slot;
  ptcl_pkg::cfg_t                 cfg;
  ptcl_pkg::bal_load_t            bal_load;
  ptcl_pkg::slot_entry_t          rd_data;
  ptcl_pkg::slot_entry_t          wr_data;
  logic                           wr_en;
  logic [ptcl_pkg::SLOT_BITS-1:0] wr_addr;
  ptcl_pkg::result_t              result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enforce_r <= 1'b1;
      mint_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptcl_pkg::CFG_ENFORCE: enforce_r <= cfg_wdata[0];
        ptcl_pkg::CFG_MINT:    mint_r    <= cfg_wdata[ptcl_pkg::TOK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept         = start && !clearing;
  assign busy           = clearing;
  assign slot           = in_request_slot[ptcl_pkg::SLOT_BITS-1:0];
  assign cfg.enforce    = enforce_r;
  assign cfg.mint       = mint_r;
  assign bal_load.load  = cfg_we && (cfg_index == ptcl_pkg::CFG_INIT_BAL);
  assign bal_load.value = cfg_wdata;

  ptcl_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (slot),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  ptcl_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_operation),
    .slot     (slot),
    .amount   (in_amount),
    .cfg      (cfg),
    .bal_load (bal_load),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .result   (result)
  );

  assign out_valid         = result.valid;
  assign out_minted        = result.minted;
  assign out_granted       = result.granted;
  assign out_bal_now       = $signed(result.bal_now);
  assign out_bal_free      = result.bal_free;
  assign out_entry_present = result.present;
  assign out_entry_count   = result.count;

endmodule

// ----- rtl/core/ptcl_checker.sv -----
// ----------------------------------------------------------------------------
// ptcl_checker
// Port-level checks of the ledger, bound to the top level.
// ----------------------------------------------------------------------------
module ptcl_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic                                 out_minted,
  input logic signed [ptcl_pkg::BAL_BITS-1:0] out_bal_now,
  input logic [ptcl_pkg::AVAIL_BITS-1:0]      out_bal_free,
  input logic                                 out_entry_present,
  input logic [ptcl_pkg::COUNT_BITS-1:0]      out_entry_count
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose outside reset");

  a_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bal_free ==
      (out_bal_now[ptcl_pkg::BAL_BITS-1] ? '0 :
       out_bal_now[ptcl_pkg::BAL_BITS-2:0])))
    else $error("available balance mismatch");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (!out_entry_present || out_minted)) |-> (out_entry_count == '0))
    else $error("count on absent or fresh slot");

endmodule

bind per_request_token_credit_ledger_top ptcl_checker u_ptcl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_minted        (out_minted),
  .out_bal_now       (out_bal_now),
  .out_bal_free      (out_bal_free),
  .out_entry_present (out_entry_present),
  .out_entry_count   (out_entry_count)
);
